// ===== sv/lnm_pkg.sv =====
// Shared types, constants and modular helpers for the Lucas number unit.
// No dependencies; every other file imports this package.
package lnm_pkg;

  localparam int VALUE_W        = 30;
  localparam int INDEX_W        = 32;
  localparam int INDEX_BITS_DEF = 32;

  localparam logic [VALUE_W-1:0] MODULUS_RESET = VALUE_W'(1000000007);

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [INDEX_W-1:0] index_t;

  // a + b mod m, for a, b < m
  function automatic value_t mod_add(value_t a, value_t b, value_t m);
    logic [VALUE_W:0] s;
    logic [VALUE_W:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, m};
    return (s >= {1'b0, m}) ? d[VALUE_W-1:0] : s[VALUE_W-1:0];
  endfunction

  // a - b mod m, for a, b < m; the wrap of the narrow sum is harmless since the result is < m
  function automatic value_t mod_sub(value_t a, value_t b, value_t m);
    return (a >= b) ? value_t'(a - b) : value_t'(a + m - b);
  endfunction

endpackage

// ===== sv/lnm_in_if.sv =====
// Input channel of the Lucas number unit: valid/ready plus the index.
// Depends on lnm_pkg.
interface lnm_in_if;
  import lnm_pkg::*;

  logic   valid;
  logic   ready;
  index_t index;

  modport source (output valid, output index, input ready);
  modport sink   (input valid, input index, output ready);
endinterface

// ===== sv/lnm_out_if.sv =====
// Output channel of the Lucas number unit: valid/ready plus the value.
// Depends on lnm_pkg.
interface lnm_out_if;
  import lnm_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/lnm_modmul.sv =====
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle, MSB first.
// Depends on lnm_pkg for widths and the modular add.
module lnm_modmul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lnm_pkg::value_t a,
  input  lnm_pkg::value_t b,
  input  lnm_pkg::value_t m,
  output logic            done,
  output lnm_pkg::value_t result
);
  import lnm_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  value_t           acc;
  value_t           a_r;
  value_t           b_r;
  value_t           m_r;
  value_t           dbl;
  value_t           acc_next;

  always_comb begin
    dbl      = mod_add(acc, acc, m_r);
    acc_next = b_r[VALUE_W-1] ? mod_add(dbl, a_r, m_r) : dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      acc <= '0;
      a_r <= a;
      b_r <= b;
      m_r <= m;
    end else if (busy) begin
      acc <= acc_next;
      b_r <= b_r << 1;
    end
  end

  assign result = acc;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("modmul started while busy");
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == '0) |=> (done && !busy))
    else $error("modmul did not finish after its last bit");
  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    (done && m_r >= VALUE_W'(2)) |-> (result < m_r))
    else $error("modmul result not reduced");

endmodule

// ===== sv/lucas_number_mod_matrix_power_unit.sv =====
// Top level: Lucas number L(n) mod a configured modulus by 2x2 matrix power.
// Depends on lnm_pkg, lnm_in_if, lnm_out_if and lnm_modmul.
//
//   channel   dir   payload            handshake
//   in_ch     in    index [31:0]       valid/ready, transaction on valid && ready
//   out_ch    out   value [29:0]       valid/ready, transaction on valid && ready
//   cfg       in    cfg_wr_data[29:0]  write on cfg_wr_en, no wait
//
// Indices 0..3 and moduli below 2 skip the matrix power. Otherwise the
// exponent k = n-3 is scanned MSB first, leading zeros skipped, then each
// remaining bit costs three products on the shared bit-serial multiplier
// plus one combine step. in_ch.ready is high only between items. Reset
// (rst, sync) restores the modulus to 1000000007 and empties the output
// register.
module lucas_number_mod_matrix_power_unit #(
  parameter int INDEX_BITS = lnm_pkg::INDEX_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [lnm_pkg::VALUE_W-1:0]  cfg_wr_data,
  lnm_in_if.sink                       in_ch,
  lnm_out_if.source                    out_ch
);
  import lnm_pkg::*;

  localparam int EXP_W = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
  localparam int BCNT_W = $clog2(EXP_W + 1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN     = 7'b0000010,
    S_MUL_GO   = 7'b0000100,
    S_MUL_WAIT = 7'b0001000,
    S_STEP     = 7'b0010000,
    S_SUM      = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    MUL_PP = 2'd0,
    MUL_QQ = 2'd1,
    MUL_PQ = 2'd2
  } mul_sel_t;

  localparam logic [2:0] SUM_FULL = 3'd7;  // 4*p + 3*q as seven additions
  localparam logic [2:0] SUM_P_N  = 3'd4;  // first four additions take p

  state_t            state;
  mul_sel_t          mul_idx;
  value_t            modulus;
  value_t            p;
  value_t            q;
  value_t            pp;
  value_t            qq;
  value_t            sum_r;
  logic [2:0]        sum_cnt;
  logic [2:0]        sum_k;
  logic [EXP_W-1:0]  expo;
  logic [BCNT_W-1:0] bitcnt;
  logic              out_valid;
  value_t            out_value;

  logic [EXP_W-1:0]  n;
  logic              mm_start;
  logic              mm_done;
  value_t            mm_a;
  value_t            mm_b;
  value_t            mm_result;
  value_t            t_two_p_q;
  value_t            np;
  value_t            addend;

  assign n = in_ch.index[EXP_W-1:0];

  always_comb begin
    // F(2k) = F(k) * (2F(k+1) - F(k))
    t_two_p_q = mod_sub(mod_add(p, p, modulus), q, modulus);
    mm_start  = (state == S_MUL_GO);
    unique case (mul_idx)
      MUL_PP: begin
        mm_a = p;
        mm_b = p;
      end
      MUL_QQ: begin
        mm_a = q;
        mm_b = q;
      end
      MUL_PQ: begin
        mm_a = q;
        mm_b = t_two_p_q;
      end
      default: begin
        mm_a = '0;
        mm_b = '0;
      end
    endcase
    np     = mod_add(pp, qq, modulus);
    addend = (sum_k < SUM_P_N) ? p : q;
  end

  lnm_modmul u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .m      (modulus),
    .done   (mm_done),
    .result (mm_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_idx   <= MUL_PP;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            sum_r <= '0;
            sum_k <= '0;
            if (modulus < VALUE_W'(2)) begin
              state <= S_DONE;
            end else if (n[EXP_W-1:2] == '0) begin
              // small index: add one the right number of times
              p     <= VALUE_W'(1);
              q     <= VALUE_W'(1);
              state <= S_SUM;
              case (n[1:0])
                2'd0:    sum_cnt <= 3'd2;
                2'd1:    sum_cnt <= 3'd1;
                2'd2:    sum_cnt <= 3'd3;
                default: sum_cnt <= 3'd4;
              endcase
            end else begin
              p      <= VALUE_W'(1);
              q      <= '0;
              expo   <= n - EXP_W'(3);
              bitcnt <= BCNT_W'(EXP_W);
              state  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (bitcnt == '0) begin
            sum_cnt <= SUM_FULL;
            state   <= S_SUM;
          end else if (!expo[EXP_W-1]) begin
            expo   <= expo << 1;
            bitcnt <= bitcnt - 1'b1;
          end else begin
            mul_idx <= MUL_PP;
            state   <= S_MUL_GO;
          end
        end
        S_MUL_GO: begin
          state <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mm_done) begin
            unique case (mul_idx)
              MUL_PP: begin
                pp      <= mm_result;
                mul_idx <= MUL_QQ;
                state   <= S_MUL_GO;
              end
              MUL_QQ: begin
                qq      <= mm_result;
                mul_idx <= MUL_PQ;
                state   <= S_MUL_GO;
              end
              default: begin
                q     <= mm_result;
                state <= S_STEP;
              end
            endcase
          end
        end
        S_STEP: begin
          // square done: (np, q); then times M on a set bit
          if (expo[EXP_W-1]) begin
            p <= mod_add(np, q, modulus);
            q <= np;
          end else begin
            p <= np;
          end
          expo   <= expo << 1;
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == BCNT_W'(1)) begin
            sum_cnt <= SUM_FULL;
            state   <= S_SUM;
          end else begin
            mul_idx <= MUL_PP;
            state   <= S_MUL_GO;
          end
        end
        S_SUM: begin
          if (sum_k == sum_cnt) begin
            state <= S_DONE;
          end else begin
            sum_r <= mod_add(sum_r, addend, modulus);
            sum_k <= sum_k + 1'b1;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ch.ready) begin
            out_value <= sum_r;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.value = out_value;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state != S_IDLE))
    else $error("transaction accepted but sequencer stayed idle");
  a_mul_wait_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_WAIT && mm_done) |=> (state == S_MUL_GO || state == S_STEP))
    else $error("sequencer lost track after a product");
  a_pair_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (p < modulus && q < modulus && pp < modulus && qq < modulus))
    else $error("matrix entries not reduced");
  a_out_reduced: assert property (@(posedge clk) disable iff (rst)
    (out_valid && modulus >= VALUE_W'(2)) |-> (out_value < modulus))
    else $error("result not reduced by the modulus");

endmodule
